[hw/rtl/phs_pkg.sv]
// shared types and constants for the polyharmonic spline derivative kernel
package phs_pkg;

  // default limits of the parameters
  localparam int MAX_DEGREE_DEF   = 5;
  localparam int MAX_EXPONENT_DEF = 7;

  // widths of the exponent, step counts and radius
  localparam int Q_W   = 4;
  localparam int CNT_W = 4;
  localparam int R_W   = 36;

  // pipeline shape of the root and divide units
  localparam int SQRT_STAGES = 16;
  localparam int DIV_STAGES  = 32;
  localparam int N_DIV       = 3;

  // saturation limits
  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  // configuration register index
  typedef enum logic {
    REG_PHS_EXPONENT = 1'b0,
    REG_POLY_DEGREE  = 1'b1
  } cfg_idx_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  // item carried down the pipeline
  typedef struct packed {
    logic [63:0]      c;
    logic [R_W-1:0]   r;
    logic             ovf;
    logic             neg;
    logic             zero;
    logic             bad;
    logic [CNT_W-1:0] mcnt;
    logic [1:0]       dcnt;
    logic [4:0]       slot;
    logic [1:0]       weight;
    logic             present;
  } item_t;

endpackage

[hw/rtl/phs_isqrt.sv]
// pipelined integer square root, two root bits per stage, with item sideband
module phs_isqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [63:0]         rs,
  input  phs_pkg::item_t      in_item,
  output logic                out_valid,
  output phs_pkg::item_t      out_item
);

  localparam int STAGES = phs_pkg::SQRT_STAGES;

  logic                 v    [STAGES+1];
  phs_pkg::item_t       itm  [STAGES+1];
  logic [63:0]          val  [STAGES+1];
  logic [35:0]          rem  [STAGES+1];
  logic [31:0]          root [STAGES+1];

  // stage zero is the unit input
  assign v[0]    = in_valid;
  assign itm[0]  = in_item;
  assign val[0]  = rs;
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [35:0] rem_next;
    logic [31:0] root_next;

    // two digit steps of the restoring root
    always_comb begin
      logic [35:0] rm;
      logic [31:0] rt;
      logic [35:0] trial;
      rm = rem[s];
      rt = root[s];
      for (int k = 0; k < 2; k++) begin
        rm    = {rm[33:0], val[s][63 - 4*s - 2*k -: 2]};
        trial = {2'b00, rt, 2'b01};
        if (rm >= trial) begin
          rm = rm - trial;
          rt = {rt[30:0], 1'b1};
        end else begin
          rt = {rt[30:0], 1'b0};
        end
      end
      rem_next  = rm;
      root_next = rt;
    end

    // valid bit
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
    end

    // payload
    always_ff @(posedge clk) begin
      if (en) begin
        itm[s+1]  <= itm[s];
        val[s+1]  <= val[s];
        rem[s+1]  <= rem_next;
        root[s+1] <= root_next;
      end
    end
  end

  // radius in Q32.32 is the root shifted up by four
  always_comb begin
    out_item   = itm[STAGES];
    out_item.r = {root[STAGES], 4'b0000};
  end
  assign out_valid = v[STAGES];

endmodule

[hw/rtl/phs_div.sv]
// pipelined Q32.32 divide of the item magnitude by the radius, two bits per stage
module phs_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic                in_act,
  input  phs_pkg::item_t      in_item,
  output logic                out_valid,
  output phs_pkg::item_t      out_item
);

  localparam int STAGES = phs_pkg::DIV_STAGES;
  localparam int RW     = phs_pkg::R_W;

  logic                 v   [STAGES+1];
  logic                 act [STAGES+1];
  phs_pkg::item_t       itm [STAGES+1];
  logic [63:0]          rem [STAGES+1];
  logic [63:0]          quo [STAGES+1];

  assign v[0]   = in_valid;
  assign act[0] = in_act;
  assign itm[0] = in_item;
  assign rem[0] = '0;
  assign quo[0] = '0;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    phs_pkg::item_t itm_next;
    logic           act_next;
    logic [63:0]    rem_next;
    logic [63:0]    quo_next;

    // overflow check on entry, then two restoring steps
    always_comb begin
      phs_pkg::item_t nit;
      logic           na;
      logic [63:0]    rm;
      logic [63:0]    qo;
      logic [64:0]    t;
      logic           bitv;
      int             i;
      nit = itm[s];
      na  = act[s];
      rm  = rem[s];
      qo  = quo[s];
      if (s == 0) begin
        rm = {32'b0, nit.c[63:32]};
        qo = '0;
        if (na && (nit.r == '0 || {{(RW-32){1'b0}}, nit.c[63:32]} >= nit.r)) begin
          nit.ovf = 1'b1;
          nit.c   = '0;
          na      = 1'b0;
        end
      end
      for (int k = 0; k < 2; k++) begin
        i = 63 - 2*s - k;
        if (i >= 32) begin
          bitv = nit.c[6'(i - 32)];
        end else begin
          bitv = 1'b0;
        end
        t = {rm, bitv};
        if (t >= {{(65-RW){1'b0}}, nit.r}) begin
          t             = t - {{(65-RW){1'b0}}, nit.r};
          qo[6'(i)]     = 1'b1;
        end
        rm = t[63:0];
      end
      if (s == STAGES - 1 && na) begin
        nit.c = qo;
      end
      itm_next = nit;
      act_next = na;
      rem_next = rm;
      quo_next = qo;
    end

    // valid bit
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
    end

    // payload
    always_ff @(posedge clk) begin
      if (en) begin
        itm[s+1] <= itm_next;
        act[s+1] <= act_next;
        rem[s+1] <= rem_next;
        quo[s+1] <= quo_next;
      end
    end
  end

  assign out_valid = v[STAGES];
  assign out_item  = itm[STAGES];

endmodule

[hw/rtl/phs_derivative_kernel.sv]
// top level of the polyharmonic spline derivative kernel pipeline
//
//   channel  signals                               direction  transfer when
//   input    in_valid in_ready node_x/y deriv_x/y  in         in_valid & in_ready
//   output   out_valid out_ready kernel_value ...  out        out_valid & out_ready
//   config   psel penable pwrite paddr pwdata      in         psel & penable & pwrite
//
// one node enters per cycle while the output queue is not full or is drained
// items pass the root unit (16 stages), the multiply steps (2 stages each)
// and three divide units of 32 stages, which are always walked through
// reset is synchronous and clears valid bits, the output queue and registers
// a two-entry output queue takes results while out_ready is low; the whole
// pipeline holds only when that queue is full and not being drained
module phs_derivative_kernel #(
  parameter int MAX_DEGREE   = phs_pkg::MAX_DEGREE_DEF,
  parameter int MAX_EXPONENT = phs_pkg::MAX_EXPONENT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] node_x,
  input  logic signed [31:0] node_y,
  input  logic [1:0]         deriv_x,
  input  logic [1:0]         deriv_y,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] kernel_value,
  output logic [4:0]         poly_slot,
  output logic [1:0]         poly_weight,
  output logic               poly_present,
  output logic [1:0]         status
);

  localparam int N_MUL = MAX_EXPONENT | 1;
  localparam int N_DIV = phs_pkg::N_DIV;
  localparam int QW    = phs_pkg::Q_W;
  localparam int CW    = phs_pkg::CNT_W;

  typedef enum logic [2:0] {
    K_ORD0, K_ORD1, K_DXX, K_DYY, K_DXY
  } kind_t;

  typedef struct packed {
    logic [63:0] kval;
    logic [4:0]  slot;
    logic [1:0]  weight;
    logic        present;
    logic [1:0]  stat;
  } res_t;

  // ---------------------------------------------------------------- config
  logic [2:0] phs_exponent;
  logic [2:0] poly_degree;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      phs_exponent <= 3'd3;
      poly_degree  <= 3'd2;
    end else if (cfg_wr) begin
      case (phs_pkg::cfg_idx_t'(paddr[2]))
        phs_pkg::REG_PHS_EXPONENT: phs_exponent <= pwdata[2:0];
        phs_pkg::REG_POLY_DEGREE:  poly_degree  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (phs_pkg::cfg_idx_t'(paddr[2]))
      phs_pkg::REG_PHS_EXPONENT: prdata = {29'b0, phs_exponent};
      phs_pkg::REG_POLY_DEGREE:  prdata = {29'b0, poly_degree};
      default:                   prdata = '0;
    endcase
  end

  // effective exponent and degree
  logic [QW-1:0] q_eff;
  logic [3:0]    deg_eff;
  logic [QW-1:0] q_m1;
  logic [QW-1:0] q_m2;
  logic [5:0]    k_mix;

  always_comb begin
    q_eff = ({1'b0, phs_exponent} > QW'(MAX_EXPONENT)) ? QW'(MAX_EXPONENT)
                                                       : QW'({1'b0, phs_exponent});
    q_eff[0] = 1'b1;
    deg_eff = ({1'b0, poly_degree} > 4'(MAX_DEGREE)) ? 4'(MAX_DEGREE)
                                                     : {1'b0, poly_degree};
    q_m1  = q_eff - QW'(1);
    q_m2  = (q_eff >= QW'(2)) ? q_eff - QW'(2) : QW'(2) - q_eff;
    k_mix = 6'(q_eff) * 6'(q_m2);
  end

  // ---------------------------------------------------------------- flow
  logic       en;
  logic [1:0] f_cnt;

  assign en       = (f_cnt != 2'd2) || out_ready;
  assign in_ready = en;

  // ---------------------------------------------------------------- stage 1
  logic            s1_v;
  logic [31:0]     s1_ax, s1_ay;
  logic            s1_xneg, s1_yneg;
  logic            s1_xsel;
  kind_t           s1_kind;
  phs_pkg::item_t  s1_item;

  kind_t           in_kind;
  phs_pkg::item_t  in_item;

  // decode order, polynomial entry and step counts
  always_comb begin
    logic [2:0]        ord;
    logic signed [5:0] e;
    ord     = {1'b0, deriv_x} + {1'b0, deriv_y};
    in_item = '0;
    in_item.bad = (ord > 3'd2);
    if (!in_item.bad && {1'b0, ord} <= deg_eff) begin
      in_item.present = 1'b1;
      case (ord)
        3'd0:    in_item.slot = 5'd0;
        3'd1:    in_item.slot = 5'd1 + {3'b0, deriv_x};
        default: in_item.slot = 5'd3 + {3'b0, deriv_x};
      endcase
      in_item.weight = (deriv_x == 2'd2 || deriv_y == 2'd2) ? 2'd2 : 2'd1;
    end
    case (ord)
      3'd0: begin
        in_kind = K_ORD0;
        e       = 6'(signed'({2'b0, q_eff}));
      end
      3'd1: begin
        in_kind = K_ORD1;
        e       = 6'(signed'({2'b0, q_eff})) - 6'sd2;
      end
      default: begin
        if (deriv_x == 2'd2) begin
          in_kind = K_DXX;
        end else if (deriv_y == 2'd2) begin
          in_kind = K_DYY;
        end else begin
          in_kind = K_DXY;
        end
        e = 6'(signed'({2'b0, q_eff})) - 6'sd4;
      end
    endcase
    in_item.mcnt = (e > 6'sd0) ? CW'(e) : '0;
    in_item.dcnt = (e < 6'sd0) ? 2'(-e) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  // absolute offsets
  always_ff @(posedge clk) begin
    if (en) begin
      s1_xneg <= node_x[31];
      s1_yneg <= node_y[31];
      s1_ax   <= node_x[31] ? 32'(-node_x) : 32'(node_x);
      s1_ay   <= node_y[31] ? 32'(-node_y) : 32'(node_y);
      s1_xsel <= (deriv_x != 2'd0);
      s1_kind <= in_kind;
      s1_item <= in_item;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic            s2_v;
  logic [63:0]     s2_xx, s2_yy, s2_axy;
  logic [31:0]     s2_a1;
  kind_t           s2_kind;
  phs_pkg::item_t  s2_item;
  phs_pkg::item_t  s1_item_sgn;

  // sign of the result
  always_comb begin
    s1_item_sgn = s1_item;
    case (s1_kind)
      K_ORD1:  s1_item_sgn.neg = s1_xsel ? !s1_xneg : !s1_yneg;
      K_DXY:   s1_item_sgn.neg = (s1_xneg != s1_yneg) != (q_eff == QW'(1));
      default: s1_item_sgn.neg = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  // squares and cross product
  always_ff @(posedge clk) begin
    if (en) begin
      s2_xx   <= 64'(s1_ax) * 64'(s1_ax);
      s2_yy   <= 64'(s1_ay) * 64'(s1_ay);
      s2_axy  <= 64'(s1_ax) * 64'(s1_ay);
      s2_a1   <= s1_xsel ? s1_ax : s1_ay;
      s2_kind <= s1_kind;
      s2_item <= s1_item_sgn;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic            s3_v;
  logic [63:0]     s3_rs;
  logic [47:0]     s3_t;
  logic            s3_mulq;
  phs_pkg::item_t  s3_item;

  logic [47:0]     t_sel;
  logic            mulq_sel;
  phs_pkg::item_t  s2_item_z;

  // coefficient before the factor q
  always_comb begin
    logic [39:0] xx24, yy24, axy24;
    xx24  = s2_xx[63:24];
    yy24  = s2_yy[63:24];
    axy24 = s2_axy[63:24];
    case (s2_kind)
      K_ORD0: begin
        t_sel    = 48'h1_0000_0000;
        mulq_sel = 1'b0;
      end
      K_ORD1: begin
        t_sel    = 48'({s2_a1, 4'b0000});
        mulq_sel = 1'b1;
      end
      K_DXX: begin
        t_sel    = 48'(q_m1) * 48'(xx24) + 48'(yy24);
        mulq_sel = 1'b1;
      end
      K_DYY: begin
        t_sel    = 48'(q_m1) * 48'(yy24) + 48'(xx24);
        mulq_sel = 1'b1;
      end
      default: begin
        t_sel    = 48'(k_mix) * 48'(axy24);
        mulq_sel = 1'b0;
      end
    endcase
  end

  // coincident node flag
  always_comb begin
    s2_item_z      = s2_item;
    s2_item_z.zero = (s2_xx == '0) && (s2_yy == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rs   <= s2_xx + s2_yy;
      s3_t    <= t_sel;
      s3_mulq <= mulq_sel;
      s3_item <= s2_item_z;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic            s4_v;
  logic [63:0]     s4_rs;
  phs_pkg::item_t  s4_item;
  phs_pkg::item_t  s3_item_c;

  // scale by q where the kind asks for it
  always_comb begin
    s3_item_c   = s3_item;
    s3_item_c.c = s3_mulq ? 64'(52'(q_eff) * 52'(s3_t)) : 64'(s3_t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_rs   <= s3_rs;
      s4_item <= s3_item_c;
    end
  end

  // ---------------------------------------------------------------- root
  logic            m_v    [N_MUL+1];
  phs_pkg::item_t  m_item [N_MUL+1];

  phs_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_v),
    .rs        (s4_rs),
    .in_item   (s4_item),
    .out_valid (m_v[0]),
    .out_item  (m_item[0])
  );

  // ---------------------------------------------------------------- multiply steps
  logic            pa_v    [N_MUL];
  phs_pkg::item_t  pa_item [N_MUL];
  logic [63:0]     pa_p    [N_MUL][4];

  for (genvar j = 0; j < N_MUL; j++) begin : g_mul
    phs_pkg::item_t mb_next;

    always_ff @(posedge clk) begin
      if (rst) begin
        pa_v[j]  <= 1'b0;
        m_v[j+1] <= 1'b0;
      end else if (en) begin
        pa_v[j]  <= m_v[j];
        m_v[j+1] <= pa_v[j];
      end
    end

    // partial products of magnitude and radius
    always_ff @(posedge clk) begin
      if (en) begin
        pa_item[j] <= m_item[j];
        pa_p[j][0] <= 64'(m_item[j].c[31:0])  * 64'(m_item[j].r[31:0]);
        pa_p[j][1] <= 64'(m_item[j].c[31:0])  * 64'(m_item[j].r[35:32]);
        pa_p[j][2] <= 64'(m_item[j].c[63:32]) * 64'(m_item[j].r[31:0]);
        pa_p[j][3] <= 64'(m_item[j].c[63:32]) * 64'(m_item[j].r[35:32]);
      end
    end

    // sum the partials, flag a product beyond 64 bits
    always_comb begin
      logic [63:0] mid;
      logic [63:0] hi;
      mid = {32'b0, pa_p[j][0][63:32]} + {32'b0, pa_p[j][1][31:0]}
          + {32'b0, pa_p[j][2][31:0]};
      hi  = pa_p[j][3] + {32'b0, pa_p[j][1][63:32]} + {32'b0, pa_p[j][2][63:32]}
          + {32'b0, mid[63:32]};
      mb_next = pa_item[j];
      if (CW'(j) < pa_item[j].mcnt && !pa_item[j].ovf) begin
        if (hi[63:32] != '0) begin
          mb_next.ovf = 1'b1;
          mb_next.c   = '0;
        end else begin
          mb_next.c = {hi[31:0], mid[31:0]};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_item[j+1] <= mb_next;
      end
    end
  end

  // ---------------------------------------------------------------- divide steps
  logic            d_v    [N_DIV+1];
  logic            d_act  [N_DIV];
  phs_pkg::item_t  d_item [N_DIV+1];

  assign d_v[0]    = m_v[N_MUL];
  assign d_item[0] = m_item[N_MUL];

  for (genvar j = 0; j < N_DIV; j++) begin : g_div
    assign d_act[j] = (d_item[j].dcnt > 2'(j)) && !d_item[j].ovf;

    phs_div u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (d_v[j]),
      .in_act    (d_act[j]),
      .in_item   (d_item[j]),
      .out_valid (d_v[j+1]),
      .out_item  (d_item[j+1])
    );
  end

  // ---------------------------------------------------------------- result
  phs_pkg::item_t fin;
  res_t           fin_res;

  assign fin = d_item[N_DIV];

  // special cases, saturation and sign
  always_comb begin
    logic [63:0] limit;
    limit   = fin.neg ? phs_pkg::NEG_LIMIT : phs_pkg::POS_LIMIT;
    fin_res = '0;
    if (fin.bad) begin
      fin_res.stat = phs_pkg::ST_ORDER;
    end else begin
      fin_res.slot    = fin.slot;
      fin_res.weight  = fin.weight;
      fin_res.present = fin.present;
      if (fin.zero) begin
        fin_res.stat = phs_pkg::ST_OK;
      end else if (fin.ovf || fin.c > limit) begin
        fin_res.kval = limit;
        fin_res.stat = phs_pkg::ST_SAT;
      end else begin
        fin_res.kval = fin.neg ? 64'(-fin.c) : fin.c;
        fin_res.stat = phs_pkg::ST_OK;
      end
    end
  end

  // ---------------------------------------------------------------- output queue
  res_t       f_data [2];
  logic       push, pop;
  logic       wr_idx;

  assign push   = en && d_v[N_DIV];
  assign pop    = out_valid && out_ready;
  assign wr_idx = 1'(f_cnt - {1'b0, pop});

  always_ff @(posedge clk) begin
    if (rst) begin
      f_cnt <= 2'd0;
    end else begin
      f_cnt <= f_cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // head entry takes a new result or shifts up, tail entry takes a new result
  always_ff @(posedge clk) begin
    if (push && !wr_idx) begin
      f_data[0] <= fin_res;
    end else if (pop) begin
      f_data[0] <= f_data[1];
    end
    if (push && wr_idx) begin
      f_data[1] <= fin_res;
    end
  end

  assign out_valid    = (f_cnt != 2'd0);
  assign kernel_value = f_data[0].kval;
  assign poly_slot    = f_data[0].slot;
  assign poly_weight  = f_data[0].weight;
  assign poly_present = f_data[0].present;
  assign status       = f_data[0].stat;

  // ---------------------------------------------------------------- checks
  a_cnt_range : assert property (@(posedge clk) disable iff (rst)
    f_cnt != 2'd3)
    else $error("output queue count out of range");

  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    (f_cnt == 2'd2 && !out_ready) |-> !in_ready)
    else $error("input taken while output queue full");

  a_order_clear : assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == phs_pkg::ST_ORDER) |-> (kernel_value == '0 && !poly_present))
    else $error("order fault result carries data");

  a_poly_absent : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !poly_present) |-> (poly_slot == '0 && poly_weight == '0))
    else $error("absent polynomial entry has slot or weight");

  a_sat_limit : assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == phs_pkg::ST_SAT) |->
      (kernel_value == phs_pkg::POS_LIMIT || kernel_value == phs_pkg::NEG_LIMIT))
    else $error("saturated result not at a limit");

endmodule
